// File: src/cc20ox_pkg.sv
// Shared types, constants and a helper function for the ChaCha20 offset stream XOR core.
`timescale 1ns / 1ps
`default_nettype none

package cc20ox_pkg;

  localparam int CTR_W        = 26;
  localparam int BLOCK_WORDS  = 8;
  localparam int STATE_WORDS  = 16;
  localparam int ROUND_STEPS  = 80;
  localparam int CFG_ADDR_W   = 6;
  localparam int CFG_DATA_W   = 64;

  localparam logic [2:0] REG_KEY0   = 3'd0;
  localparam logic [2:0] REG_KEY1   = 3'd1;
  localparam logic [2:0] REG_KEY2   = 3'd2;
  localparam logic [2:0] REG_KEY3   = 3'd3;
  localparam logic [2:0] REG_NONCE0 = 3'd4;
  localparam logic [2:0] REG_NONCE1 = 3'd5;
  localparam logic [2:0] REG_ENABLE = 3'd6;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_ROUND  = 6'b000010,
    ST_FINAL  = 6'b000100,
    ST_WRITE  = 6'b001000,
    ST_FETCH  = 6'b010000,
    ST_LOOKUP = 6'b100000
  } state_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

endpackage

`default_nettype wire

// File: src/chacha20_offset_stream_xor_core.sv
// Top level of the ChaCha20 (IETF) offset-addressed stream XOR core.
`timescale 1ns / 1ps
`default_nettype none

// Each input word carries a data byte and its absolute offset; the byte is XORed with
// the matching ChaCha20 keystream byte for block offset/64, position offset%64. The
// last keystream block is held in an 8 x 64-bit cache RAM. A word whose block is in the
// cache, or any word while the cipher is disabled, is read from the cache RAM when it
// is accepted, and its result is formed in the lookup state. A word that needs a new
// block loads the initial state, then runs 80 quarter-round steps (four lanes in
// parallel, one add-xor-rotate step per cycle), the final addition, the write of the
// block into the cache RAM through its single write port, a new cache RAM read, and
// the lookup. The result register lets a new word be accepted while a finished result
// still waits to be taken. Writing any key or nonce register drops the cached block.

module chacha20_offset_stream_xor_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output      logic                                in_stall,
  input  wire logic [7:0]                          data_byte,
  input  wire logic [31:0]                         byte_offset,
  input  wire logic                                end_of_buffer,
  output      logic                                out_valid,
  input  wire logic                                out_stall,
  output      logic [7:0]                          result_byte,
  output      logic                                result_last,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [cc20ox_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [cc20ox_pkg::CFG_DATA_W-1:0]   pwdata,
  output      logic [cc20ox_pkg::CFG_DATA_W-1:0]   prdata,
  output      logic                                pready
);

  import cc20ox_pkg::*;

  localparam int WADDR_W = $clog2(BLOCK_WORDS);

  logic [63:0]        key0, key1, key2, key3, nonce_low;
  logic [31:0]        nonce_high;
  logic               cipher_enable;
  logic               cache_valid;
  logic [CTR_W-1:0]   cached_counter;

  state_t             state, state_next;
  logic [6:0]         rnd_cnt;
  logic [WADDR_W-1:0] wr_cnt;
  logic [CTR_W-1:0]   ctr_q;
  logic [5:0]         pos_q;
  logic [7:0]         byte_q;
  logic               last_q;
  logic               enc_q;

  logic [31:0]        ws [STATE_WORDS];
  logic [31:0]        ws_rnd [STATE_WORDS];
  logic [31:0]        init_w [STATE_WORDS];
  logic [CTR_W-1:0]   init_ctr;

  logic               cfg_wr;
  logic [2:0]         cfg_idx;
  logic               in_acc;
  logic               hit;
  logic               out_free;
  logic               ram_we, ram_re;
  logic [WADDR_W-1:0] ram_raddr;
  logic [63:0]        ram_rdata;
  logic [7:0]         ks_byte;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_comb begin
    case (cfg_idx)
      REG_KEY0:   prdata = key0;
      REG_KEY1:   prdata = key1;
      REG_KEY2:   prdata = key2;
      REG_KEY3:   prdata = key3;
      REG_NONCE0: prdata = nonce_low;
      REG_NONCE1: prdata = {32'd0, nonce_high};
      REG_ENABLE: prdata = {63'd0, cipher_enable};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key0          <= '0;
      key1          <= '0;
      key2          <= '0;
      key3          <= '0;
      nonce_low     <= '0;
      nonce_high    <= '0;
      cipher_enable <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_KEY0:   key0          <= pwdata;
        REG_KEY1:   key1          <= pwdata;
        REG_KEY2:   key2          <= pwdata;
        REG_KEY3:   key3          <= pwdata;
        REG_NONCE0: nonce_low     <= pwdata;
        REG_NONCE1: nonce_high    <= pwdata[31:0];
        REG_ENABLE: cipher_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign hit      = cache_valid && (cached_counter == byte_offset[31:6]);
  assign out_free = ~out_valid | ~out_stall;

  assign init_ctr = (state == ST_IDLE) ? byte_offset[31:6] : ctr_q;

  always_comb begin
    init_w[0]  = SIGMA0;
    init_w[1]  = SIGMA1;
    init_w[2]  = SIGMA2;
    init_w[3]  = SIGMA3;
    init_w[4]  = key0[31:0];
    init_w[5]  = key0[63:32];
    init_w[6]  = key1[31:0];
    init_w[7]  = key1[63:32];
    init_w[8]  = key2[31:0];
    init_w[9]  = key2[63:32];
    init_w[10] = key3[31:0];
    init_w[11] = key3[63:32];
    init_w[12] = {{(32-CTR_W){1'b0}}, init_ctr};
    init_w[13] = nonce_low[31:0];
    init_w[14] = nonce_low[63:32];
    init_w[15] = nonce_high;
  end

  // One quarter-round step on all four lanes; bit 2 of the step count picks the
  // diagonal lane mapping, bits 1:0 pick which of the four steps runs.
  always_comb begin
    logic        diag;
    logic [1:0]  step;
    logic [31:0] va, vb, vc, vd, sum, mix;
    diag = rnd_cnt[2];
    step = rnd_cnt[1:0];
    ws_rnd = ws;
    for (int l = 0; l < 4; l++) begin
      va = ws[l];
      vb = diag ? ws[4 + ((l + 1) & 3)]  : ws[4 + l];
      vc = diag ? ws[8 + ((l + 2) & 3)]  : ws[8 + l];
      vd = diag ? ws[12 + ((l + 3) & 3)] : ws[12 + l];
      if (!step[0]) begin
        sum = va + vb;
        mix = step[1] ? rotl32(vd ^ sum, 8) : rotl32(vd ^ sum, 16);
        ws_rnd[l] = sum;
        if (diag) begin
          ws_rnd[12 + ((l + 3) & 3)] = mix;
        end else begin
          ws_rnd[12 + l] = mix;
        end
      end else begin
        sum = vc + vd;
        mix = step[1] ? rotl32(vb ^ sum, 7) : rotl32(vb ^ sum, 12);
        if (diag) begin
          ws_rnd[8 + ((l + 2) & 3)] = sum;
          ws_rnd[4 + ((l + 1) & 3)] = mix;
        end else begin
          ws_rnd[8 + l] = sum;
          ws_rnd[4 + l] = mix;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (cipher_enable && !hit) begin
            state_next = ST_ROUND;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_ROUND: begin
        if (rnd_cnt == 7'(ROUND_STEPS - 1)) begin
          state_next = ST_FINAL;
        end
      end
      ST_FINAL: state_next = ST_WRITE;
      ST_WRITE: begin
        if (wr_cnt == WADDR_W'(BLOCK_WORDS - 1)) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      rnd_cnt        <= '0;
      wr_cnt         <= '0;
      cache_valid    <= 1'b0;
      cached_counter <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      rnd_cnt <= (state == ST_ROUND) ? rnd_cnt + 7'd1 : '0;
      wr_cnt  <= (state == ST_WRITE) ? wr_cnt + WADDR_W'(1) : '0;
      if (state == ST_WRITE && wr_cnt == WADDR_W'(BLOCK_WORDS - 1)) begin
        cache_valid    <= 1'b1;
        cached_counter <= ctr_q;
      end
      if (cfg_wr && cfg_idx <= REG_NONCE1) begin
        cache_valid <= 1'b0;
      end
      if (state == ST_LOOKUP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign ks_byte = ram_rdata[{pos_q[2:0], 3'b000} +: 8];

  always_ff @(posedge clk) begin
    if (in_acc) begin
      byte_q <= data_byte;
      pos_q  <= byte_offset[5:0];
      last_q <= end_of_buffer;
      ctr_q  <= byte_offset[31:6];
      enc_q  <= cipher_enable;
    end
    if (state == ST_LOOKUP && out_free) begin
      result_byte <= byte_q ^ (enc_q ? ks_byte : 8'd0);
      result_last <= last_q;
    end
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          ws <= init_w;
        end
      end
      ST_ROUND: ws <= ws_rnd;
      ST_FINAL: begin
        for (int i = 0; i < STATE_WORDS; i++) begin
          ws[i] <= ws[i] + init_w[i];
        end
      end
      ST_WRITE: begin
        for (int i = 0; i < STATE_WORDS - 2; i++) begin
          ws[i] <= ws[i + 2];
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we    = (state == ST_WRITE);
  assign ram_re    = in_acc | (state == ST_FETCH);
  assign ram_raddr = (state == ST_IDLE) ? byte_offset[5:3] : pos_q[5:3];

  cc20ox_ram #(
    .WIDTH(64),
    .DEPTH(BLOCK_WORDS)
  ) u_cache (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_cnt),
    .wdata({ws[1], ws[0]}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  a_cache_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(cache_valid) |-> $past(state == ST_WRITE && wr_cnt == WADDR_W'(BLOCK_WORDS - 1)))
    else $error("cache marked valid outside the end of a block write");

  a_cfg_drop: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && cfg_idx <= REG_NONCE1 |=> !cache_valid)
    else $error("key or nonce write left the cached block valid");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_LOOKUP))
    else $error("result word raised without a lookup");

endmodule

`default_nettype wire

// File: src/cc20ox_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module cc20ox_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire
